// ===== rtl/core/iafmt_pkg.sv =====
// ----------------------------------------------------------------------------
// iafmt_pkg: integer to ASCII formatter shared types and constants
// Beat structs, conversion stage record and character codes.
// ----------------------------------------------------------------------------
package iafmt_pkg;

  localparam int ValueW     = 64;
  localparam int WordW      = 32;
  localparam int DigitsN    = 20;
  localparam int BcdW       = 4 * DigitsN;
  localparam int StagesN    = 8;
  localparam int StageBits  = ValueW / StagesN;
  localparam int HexDigitsN = WordW / 4;
  localparam int RemW       = $clog2(DigitsN + 1);

  localparam logic [1:0] KindHex   = 2'd0;
  localparam logic [1:0] KindDec32 = 2'd1;

  localparam logic [1:0] PfxNone = 2'd0;
  localparam logic [1:0] PfxX    = 2'd1;
  localparam logic [1:0] PfxZero = 2'd2;

  localparam logic [6:0] CharZero = 7'h30;
  localparam logic [6:0] CharX    = 7'h78;
  localparam logic [6:0] CharA    = 7'h61;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_t;

  typedef struct packed {
    logic              hex;
    logic [WordW-1:0]  word;
    logic [ValueW-1:0] bin;
    logic [BcdW-1:0]   bcd;
  } conv_t;

endpackage

// ===== rtl/core/iafmt_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// iafmt_dabble_stage: one registered double-dabble stage
// Shifts StageBits binary bits into the BCD digits, add-3 before each shift.
// ----------------------------------------------------------------------------
module iafmt_dabble_stage
  import iafmt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  conv_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output conv_t dn_data
);

  conv_t work;

  always_comb begin
    work = up_data;
    for (int s = 0; s < StageBits; s++) begin
      for (int d = 0; d < DigitsN; d++) begin
        if (work.bcd[d*4 +: 4] >= 4'd5) begin
          work.bcd[d*4 +: 4] = work.bcd[d*4 +: 4] + 4'd3;
        end
      end
      work.bcd = {work.bcd[BcdW-2:0], work.bin[ValueW-1]};
      work.bin = {work.bin[ValueW-2:0], 1'b0};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= work;
    end
  end

endmodule

// ===== rtl/core/iafmt_serializer.sv =====
// ----------------------------------------------------------------------------
// iafmt_serializer: character emitter
// Walks the converted digits most significant first, one character a beat.
// ----------------------------------------------------------------------------
module iafmt_serializer
  import iafmt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  conv_t up_data,
  output logic  dst_valid,
  input  logic  dst_stall,
  output out_t  dst_data
);

  function automatic logic [6:0] nib_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CharZero + {3'b000, nib};
    end
    return CharA + {3'b000, nib} - 7'd10;
  endfunction

  logic            busy;
  logic            hex;
  logic [1:0]      pfx;
  logic [BcdW-1:0] sh;
  logic [RemW-1:0] rem;
  logic            lead;

  logic [3:0] top;
  logic       in_pfx;
  logic       skip;
  logic       can_out;
  logic       emit;
  logic       digit_emit;
  logic       load;

  assign top        = sh[BcdW-1 -: 4];
  assign in_pfx     = hex && (pfx != PfxNone);
  assign skip       = busy && !hex && lead && (top == 4'd0) && (rem > RemW'(1));
  assign can_out    = !dst_valid || !dst_stall;
  assign emit       = busy && !skip && can_out;
  assign digit_emit = emit && !in_pfx;
  assign up_ready   = !busy;
  assign load       = up_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (emit) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (digit_emit && rem == RemW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hex  <= up_data.hex;
      pfx  <= up_data.hex ? PfxZero : PfxNone;
      sh   <= up_data.hex ? {up_data.word, {(BcdW-WordW){1'b0}}} : up_data.bcd;
      rem  <= up_data.hex ? RemW'(HexDigitsN) : RemW'(DigitsN);
      lead <= 1'b1;
    end else if (emit && in_pfx) begin
      pfx <= pfx - 2'd1;
    end else if (skip || digit_emit) begin
      sh  <= {sh[BcdW-5:0], 4'd0};
      rem <= rem - RemW'(1);
      if (digit_emit) begin
        lead <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (in_pfx) begin
        dst_data.character <= (pfx == PfxZero) ? CharZero : CharX;
        dst_data.last      <= 1'b0;
      end else begin
        dst_data.character <= nib_char(top);
        dst_data.last      <= (rem == RemW'(1));
      end
    end
  end

endmodule

// ===== rtl/core/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit: number to ASCII text
// Hex32 with 0x prefix, or decimal of 32 or 64 bits, one character a beat.
//
//   channel | direction | payload | beats per number
//   src     | in        | in_t    | 1
//   dst     | out       | out_t   | hex 10, decimal 1 to 20
//
// Eight double-dabble stages (8 bits each) convert the value; the serializer
// then loads it and emits its characters. It walks every digit position,
// leading zeros included (decimal 20, hex 10), and takes no new number until
// the last character is out, while the stages convert the following numbers.
// Reset is synchronous and empties every stage. A dst stall holds character
// output; the stages fill and then src stalls.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit
  import iafmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_stall,
  input  in_t  src_data,
  output logic dst_valid,
  input  logic dst_stall,
  output out_t dst_data
);

  logic         stg_valid [StagesN+1];
  logic         stg_ready [StagesN+1];
  conv_t        stg_data  [StagesN+1];

  assign stg_valid[0]     = src_valid;
  assign stg_data[0].hex  = (src_data.kind == KindHex);
  assign stg_data[0].word = src_data.value[WordW-1:0];
  assign stg_data[0].bin  = src_data.kind[1] ? src_data.value
                          : {{(ValueW-WordW){1'b0}}, src_data.value[WordW-1:0]};
  assign stg_data[0].bcd  = '0;
  assign src_stall        = !stg_ready[0];

  for (genvar g = 0; g < StagesN; g++) begin : g_stage
    iafmt_dabble_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  iafmt_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (stg_valid[StagesN]),
    .up_ready  (stg_ready[StagesN]),
    .up_data   (stg_data[StagesN]),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule
